// ===== src/fnv1a_jump_hash_shard_router_top_macros.svh =====
// fnv1a_jump_hash_shard_router_top_macros.svh
// Assertion macros for the shard router RTL. No dependencies; expects i_clk
// and i_rst_n in the including module.
`ifndef FNV1A_JUMP_HASH_SHARD_ROUTER_TOP_MACROS_SVH
`define FNV1A_JUMP_HASH_SHARD_ROUTER_TOP_MACROS_SVH

// property must hold at every edge out of reset
`define FJH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define FJH_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== src/fjh_pkg.sv =====
// fjh_pkg.sv
// Types, constants and the FNV-1a byte step for the shard router.
// No dependencies.
package fjh_pkg;

    localparam logic [63:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] JUMP_MUL   = 64'h27BB_2EE6_87B0_B0FD;
    localparam int          JUMP_SHIFT = 33;
    localparam int          JUMP_ONE_SH = 31;
    // divisor is (key >> 33) + 1, at most 2^31
    localparam int          DEN_W      = 64 - JUMP_SHIFT + 1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } t_state;

    // one FNV-1a round: xor the byte, multiply by 2^40 + 0x1B3 mod 2^64
    function automatic logic [63:0] fnv_step(input logic [63:0] acc,
                                             input logic [7:0]  din);
        logic [63:0] x;
        x = acc ^ {56'd0, din};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
             + (x << 1) + x;
    endfunction

endpackage

// ===== src/fjh_mul.sv =====
// fjh_mul.sv
// 64x64 multiplier, low 64 bits, from three 32x32 partial products.
// Depends on fjh_pkg.
module fjh_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output fjh_pkg::t_unit_sts o_sts,
    output logic [63:0]       o_prod
);
    import fjh_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_prod;
    logic [63:0] r_acc;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] addend;

    always_comb begin
        case (r_step)
            2'd0: begin
                op_x = r_a[31:0];
                op_y = r_b[31:0];
            end
            2'd1: begin
                op_x = r_a[31:0];
                op_y = r_b[63:32];
            end
            2'd2: begin
                op_x = r_a[63:32];
                op_y = r_b[31:0];
            end
            default: begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    // product of the previous step; cross terms land in the upper word
    always_comb begin
        case (r_step)
            2'd0:    addend = '0;
            2'd1:    addend = r_prod;
            default: addend = {r_prod[31:0], 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_prod <= {32'd0, op_x} * {32'd0, op_y};
            r_acc  <= r_acc + addend;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

// ===== src/fjh_div.sv =====
// fjh_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be non-zero.
// Depends on fjh_pkg.
module fjh_div #(
    parameter int NUM_W = 48,
    parameter int DV_W  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DV_W-1:0]    i_den,
    output fjh_pkg::t_unit_sts o_sts,
    output logic [NUM_W-1:0]   o_quot
);
    import fjh_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DV_W-1:0]  r_rem;
    logic [DV_W-1:0]  r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DV_W:0]    trial;
    logic [DV_W:0]    diff;
    logic             fits;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], fits};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

// ===== src/fnv1a_jump_hash_shard_router_top.sv =====
// fnv1a_jump_hash_shard_router_top.sv
// Shard router top: FNV-1a byte hashing and jump consistent hash sequencer.
// Depends on fjh_pkg, fjh_mul, fjh_div and the assertion macro header.
//
//  channel   dir  beat carries
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tdata[7:0] data_byte, tlast last_byte, tuser replicated
//  m_axis    out  tdata[15:0] shard_index, tdata[79:16] key_hash
//  cfg       in   i_cfg_wdata = shard_count, written when i_cfg_we is high
//
//  Flow: a byte that is not last is folded into the hash in S_IDLE. A last byte
//  goes to S_DONE when no jump is run, else through k jump steps, k about
//  ln(shard_count) + 1, each S_CHECK, S_MUL, S_DIV_GO and S_DIV; the bit-serial
//  divider works QUOT_W = min(SHARD_BITS, 16) + 32 quotient bits a step.
//  Reset: synchronous, active low; shard_count to 1, hash to offset basis.
//  Stalls: s_axis_tready is low while a key end is worked; a result waiting
//  on m_axis holds the next key end in its final state, not plain bytes.
`include "fnv1a_jump_hash_shard_router_top_macros.svh"

module fnv1a_jump_hash_shard_router_top #(
    parameter int SHARD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,   // shard_count
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // last_byte
    input  logic        s_axis_tuser,  // [0] replicated
    // result out
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [79:0] m_axis_tdata   // [15:0] shard_index, [79:16] key_hash
);
    import fjh_pkg::*;

    // bucket / count width: count register is 17 bits, clipped at 2^SHARD_BITS
    localparam int CNT_W  = (SHARD_BITS >= 17) ? 17 : SHARD_BITS + 1;
    localparam int QUOT_W = CNT_W + JUMP_ONE_SH;
    localparam logic [31:0] SHARD_LIM = 32'(1) << SHARD_BITS;

    t_state           r_state, n_state;
    logic [16:0]      r_shard_count;
    logic [63:0]      r_acc, n_acc;
    logic [63:0]      r_key, n_key;
    logic [QUOT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_b, n_b;
    logic [63:0]      r_hash, n_hash;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_shard, n_out_shard;
    logic [63:0]      r_out_hash, n_out_hash;

    logic             in_beat;
    logic [63:0]      fnv_h;
    logic [31:0]      cnt_ext;
    logic [31:0]      eff32;
    logic [CNT_W-1:0] eff_n;
    logic             do_jump;
    logic [31:0]      b_ext;
    logic [CNT_W-1:0] b_inc;

    logic             mul_start;
    t_unit_sts        mul_sts;
    logic [63:0]      mul_prod;
    logic             div_start;
    t_unit_sts        div_sts;
    logic [QUOT_W-1:0] div_quot;
    logic [QUOT_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign fnv_h   = fnv_step(r_acc, s_axis_tdata);

    // zero counts as one shard, large counts clip to 2^SHARD_BITS
    assign cnt_ext = 32'(r_shard_count);
    assign eff32   = (r_shard_count == '0)  ? 32'd1 :
                     (cnt_ext > SHARD_LIM)  ? SHARD_LIM : cnt_ext;
    assign eff_n   = eff32[CNT_W-1:0];
    assign do_jump = !s_axis_tuser && (eff32 > 32'd1);

    assign b_ext   = 32'(r_b);
    assign b_inc   = r_b + CNT_W'(1);
    assign div_num = {b_inc, {JUMP_ONE_SH{1'b0}}};
    assign div_den = {1'b0, r_key[63:JUMP_SHIFT]} + DEN_W'(1);

    fjh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_key),
        .i_b     (JUMP_MUL),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    fjh_div #(
        .NUM_W (QUOT_W),
        .DV_W  (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // sequencer: one jump step = key update on the multiplier, then the
    // quotient on the divider, then the bound test against the count
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_key       = r_key;
        n_j         = r_j;
        n_b         = r_b;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_shard = r_out_shard;
        n_out_hash  = r_out_hash;
        s_axis_tready = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_beat) begin
                    if (!s_axis_tlast) begin
                        n_acc = fnv_h;
                    end else begin
                        n_acc  = FNV_BASIS;
                        n_hash = fnv_h;
                        n_b    = '0;
                        if (do_jump) begin
                            n_key   = fnv_h;
                            n_j     = '0;
                            n_state = S_CHECK;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (r_j < QUOT_W'(eff_n)) begin
                    n_b       = r_j[CNT_W-1:0];
                    mul_start = 1'b1;
                    n_state   = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    n_key   = mul_prod + 64'd1;
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_j     = div_quot;
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_shard = b_ext[15:0];
                    n_out_hash  = r_hash;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_acc         <= FNV_BASIS;
            r_out_valid   <= 1'b0;
            r_shard_count <= 17'd1;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_shard_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_j         <= n_j;
        r_b         <= n_b;
        r_hash      <= n_hash;
        r_out_shard <= n_out_shard;
        r_out_hash  <= n_out_hash;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_hash, r_out_shard};

    `FJH_NEVER(a_units_excl, mul_sts.busy && div_sts.busy, "multiplier and divider both busy")
    `FJH_ASSERT(a_out_from_done, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result loaded outside final state")
    `FJH_ASSERT(a_div_from_go, $rose(div_sts.busy) |-> $past(r_state == S_DIV_GO), "divider started out of sequence")
    `FJH_ASSERT(a_mul_from_check, $rose(mul_sts.busy) |-> $past(r_state == S_CHECK), "multiplier started out of sequence")

endmodule

// ===== verif/tb_top.sv =====
// tb_top.sv
// Self-checking bench for fnv1a_jump_hash_shard_router_top: routing strings go in as byte
// beats, and each result beat is checked against a local FNV-1a / jump hash predictor.
module tb_top;

    // FNV-1a 64 and jump hash constants, kept locally for the predictor
    localparam logic [63:0] FNV_OFFSET     = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_MULTIPLIER = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] JUMP_LCG_MUL   = 64'h27BB_2EE6_87B0_B0FD;
    localparam int          KEY_SHIFT      = 33;
    localparam int          QUOT_SHIFT     = 31;
    localparam logic [63:0] SHARD_CAP      = 64'd65536;  // 2^SHARD_BITS at the default

    localparam int TARGET_BYTES = 1900;
    localparam int HOLD_CYCLES  = 600;    // long m_axis hold-off
    localparam int QUIET_CYCLES = 8;      // settle time before a register write
    localparam int TAIL_CYCLES  = 200;    // watch for stray beats at the end
    localparam int CYCLE_LIMIT  = 3000000;

    localparam logic [7:0] SEP_BYTE = 8'h3A;  // ':' between table name and key

    typedef struct packed {
        logic [15:0] shard;
        logic [63:0] hash;
    } t_route;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [16:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0; // last_byte
    logic        s_axis_tuser  = 1'b0; // [0] replicated
    logic        m_axis_tready = 1'b0;
    logic        m_axis_tvalid;
    logic [79:0] m_axis_tdata;         // [15:0] shard_index, [79:16] key_hash

    // predictor state, mirrors the block after reset
    logic [63:0] hash_acc  = FNV_OFFSET;
    logic [16:0] shard_cfg = 17'd1;
    t_route      pending_routes[$];

    int  bytes_sent  = 0;
    int  mismatches  = 0;
    int  cycle_count = 0;
    // both sides idle at random while this is set; cleared for the last stretch
    logic idle_on = 1'b1;
    // hold-off request: bumped by the stimulus, seen and counted by the receiver
    int  hold_seq   = 0;
    int  hold_seen  = 0;
    int  hold_left  = 0;
    int  stall_left = 0;

    fnv1a_jump_hash_shard_router_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fnv1a_jump_hash_shard_router_top: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // zero means one shard; anything past 2^SHARD_BITS is clipped
    function automatic logic [63:0] live_shards(input logic [16:0] cfg);
        if (cfg == 17'd0)
            return 64'd1;
        if ({47'd0, cfg} > SHARD_CAP)
            return SHARD_CAP;
        return {47'd0, cfg};
    endfunction

    // jump consistent hash, quotient done as an exact integer divide
    function automatic logic [15:0] jump_shard(input logic [63:0] key,
                                               input logic [63:0] buckets);
        logic [63:0] k;
        logic [63:0] b;
        logic [63:0] j;
        k = key;
        b = '0;
        j = '0;
        while (j < buckets) begin
            b = j;
            k = k * JUMP_LCG_MUL + 64'd1;
            j = ((b + 64'd1) << QUOT_SHIFT) / ((k >> KEY_SHIFT) + 64'd1);
        end
        return b[15:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("route check failed on %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // Sender: offer one byte beat, fold it into the predictor once taken
    // ---------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic last, input logic repl);
        logic [63:0] h;
        logic [63:0] n;
        t_route      r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        s_axis_tuser  <= repl;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
        h = (hash_acc ^ {56'd0, d}) * FNV_MULTIPLIER;
        if (!last) begin
            // mid-string byte: replicated flag has no effect
            hash_acc = h;
        end else begin
            n = live_shards(shard_cfg);
            r.shard = (!repl && n > 64'd1) ? jump_shard(h, n) : 16'd0;
            r.hash  = h;
            pending_routes = {pending_routes, r};
            hash_acc = FNV_OFFSET;
        end
        // random gap on the input side; valid only drops when a gap is taken
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge i_clk);
        end
    endtask

    // one routing string: mostly lower-case text, some raw bytes, often a ':'
    task automatic send_key(input int len, input logic repl);
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            if (len > 2 && i == len / 2 && $urandom_range(0, 1) == 1)
                d = SEP_BYTE;
            else if ($urandom_range(0, 1) == 1)
                d = 8'($urandom_range(8'h61, 8'h7A));
            else
                d = 8'($urandom_range(0, 255));
            send_byte(d, i == len - 1, (i == len - 1) ? repl : 1'($urandom_range(0, 1)));
        end
    endtask

    // stop offering and wait until every predicted result beat has been seen
    task automatic drain_routes();
        s_axis_tvalid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES)
            @(posedge i_clk);
    endtask

    // shard_count only changes with the block idle
    task automatic set_shard_count(input logic [16:0] v);
        drain_routes();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        shard_cfg = v;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: check each taken result beat, then pick next cycle's tready
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_side
        t_route want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_routes.size() == 0) begin
                note_mismatch("result beat with nothing pending", m_axis_tdata[79:16], '0);
            end else begin
                want = pending_routes.pop_front();
                if (m_axis_tdata[15:0] !== want.shard)
                    note_mismatch("shard_index", {48'd0, m_axis_tdata[15:0]},
                                  {48'd0, want.shard});
                if (m_axis_tdata[79:16] !== want.hash)
                    note_mismatch("key_hash", m_axis_tdata[79:16], want.hash);
            end
        end
        if (hold_seen != hold_seq) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            // start a stall burst
            stall_left    <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // out of reset shard_count is 1: every key lands on shard 0
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(SEP_BYTE, 1'b1, 1'b1);
    endtask

    // zero, two, exactly 2^16, just past it, the 17-bit maximum, then one again
    task automatic test_shard_count_limits();
        set_shard_count(17'd0);
        send_byte(8'h80, 1'b1, 1'b0);
        set_shard_count(17'd2);
        send_byte(8'h61, 1'b0, 1'b0);
        send_byte(SEP_BYTE, 1'b0, 1'b0);
        send_byte(8'h62, 1'b1, 1'b0);
        set_shard_count(17'd65536);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        set_shard_count(17'd65537);
        send_byte(8'h7F, 1'b0, 1'b1);
        send_byte(8'h01, 1'b1, 1'b0);
        set_shard_count(17'h1FFFF);
        send_byte(8'hFF, 1'b1, 1'b0);
        set_shard_count(17'd1);
        send_byte(8'h55, 1'b1, 1'b0);
    endtask

    // replicated table forces shard 0 but keeps the true hash; a normal key follows
    task automatic test_replicated_flag();
        set_shard_count(17'd65536);
        send_byte(8'h74, 1'b0, 1'b1);
        send_byte(SEP_BYTE, 1'b0, 1'b1);
        send_byte(8'h6B, 1'b1, 1'b1);
        send_byte(8'h6B, 1'b1, 1'b0);
    endtask

    // hold m_axis off for a long stretch while short keys keep coming, so a
    // finished result blocks the next key end and s_axis_tready drops
    task automatic test_output_backpressure();
        set_shard_count(17'd16);
        idle_on  <= 1'b0;
        hold_seq <= hold_seq + 1;
        repeat (12)
            send_key(3, 1'($urandom_range(0, 1)));
        idle_on <= 1'b1;
    endtask

    // bursts separated by a full drain of the output side
    task automatic test_sender_pause();
        set_shard_count(17'd7);
        repeat (4)
            send_key($urandom_range(1, 6), 1'b0);
        drain_routes();
        repeat (4)
            send_key($urandom_range(1, 6), 1'($urandom_range(0, 1)));
    endtask

    // phases of random keys; shard_count mostly small, now and then large
    task automatic test_random_routing();
        int          pick;
        int          keys;
        logic [16:0] cnt;
        while (bytes_sent < TARGET_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                cnt = 17'($urandom_range(0, 64));
            else if (pick < 9)
                cnt = 17'($urandom_range(65, 4096));
            else
                cnt = 17'($urandom_range(40000, 131071));
            // sometimes leave a string half sent across the register write
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), 1'b0,
                              1'($urandom_range(0, 1)));
            set_shard_count(cnt);
            idle_on <= (bytes_sent < TARGET_BYTES * 85 / 100) &&
                       ($urandom_range(0, 3) != 0);
            keys = (pick == 9) ? $urandom_range(4, 10) : $urandom_range(8, 24);
            repeat (keys)
                send_key($urandom_range(1, 12), $urandom_range(0, 6) == 0);
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (12)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_shard_count_limits();
        test_replicated_flag();
        test_output_backpressure();
        test_sender_pause();
        test_random_routing();

        s_axis_tvalid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES)
            @(posedge i_clk);

        if (mismatches == 0)
            $display("fnv1a_jump_hash_shard_router_top: match");
        else
            $display("fnv1a_jump_hash_shard_router_top: mismatch");
        $finish;
    end

endmodule
